/* src/tbt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbt_pkg
// Shared constants, register indexes and helper types for the band tiler.
// ----------------------------------------------------------------------------
package tbt_pkg;

   localparam int unsigned MaxTilesDefault  = 16;
   localparam int unsigned CoordBitsDefault = 40;
   localparam int unsigned HeightBits       = 39;
   localparam int unsigned CountBits        = 5;
   localparam int unsigned FeedBits         = 16;
   localparam int unsigned TileBits         = 4;
   localparam int unsigned AddrBits         = 5;

   localparam logic [HeightBits-1:0] HeightReset = 39'd508000000;
   localparam logic [CountBits-1:0]  CountReset  = 5'd1;
   localparam longint                SafeZReset  = 64'sd5000000;

   typedef enum logic [1:0] {
      REG_TILE_HEIGHT = 2'd0,
      REG_TILE_COUNT  = 2'd1,
      REG_SAFE_Z      = 2'd2
   } reg_index_type;

   localparam logic [0:0] KIND_RAPID = 1'b0;
   localparam logic [0:0] KIND_FEED  = 1'b1;

   // Control handed from the sequencer to the shared divider.
   typedef struct packed {
      logic start;
      logic negate;
   } div_ctl_type;

endpackage
`default_nettype wire

/* src/toolpath_band_tiler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// toolpath_band_tiler
// Splits feed moves into horizontal bands and relinks each band's program.
//
// The req_ channel carries one move (rapid or feed). A rapid only updates the
// tracked tool position and gives no result. A feed is clipped against every
// band in use, bottom band first; each surviving piece goes out on the rsp_
// channel, preceded by retract, rapid and plunge moves when the band's last
// position differs from the piece start. rsp_last marks the final result.
// One item is worked on at a time and req_ready is low meanwhile. For each
// band that a sloped segment crosses, six interpolations run on the shared
// serial multiply-divide unit of width WW (WW = max(COORD_BITS, 44) + 2, so
// 46 at the defaults). A stalled receiver holds the block in its output
// state; nothing is dropped. Reset sets the position to x = 0, y = 0 and the
// default safe height, clears the plunge rate and every band's has-position
// flag and restores the register defaults. Make writes on the csr_ port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module toolpath_band_tiler #(
   parameter int unsigned MAX_TILES  = tbt_pkg::MaxTilesDefault,
   parameter int unsigned COORD_BITS = tbt_pkg::CoordBitsDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic signed [COORD_BITS-1:0] req_target_x,
   input  wire logic signed [COORD_BITS-1:0] req_target_y,
   input  wire logic signed [COORD_BITS-1:0] req_target_z,
   input  wire logic [tbt_pkg::FeedBits-1:0] req_feed_rate,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [tbt_pkg::TileBits-1:0]      rsp_tile_index,
   output logic                              rsp_move_kind,
   output logic signed [COORD_BITS-1:0]      rsp_out_x,
   output logic signed [COORD_BITS-1:0]      rsp_out_y,
   output logic signed [COORD_BITS-1:0]      rsp_out_z,
   output logic [tbt_pkg::FeedBits-1:0]      rsp_out_feed,
   output logic                              rsp_last,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [tbt_pkg::AddrBits-1:0] csr_paddr,
   input  wire logic [63:0]                  csr_pwdata,
   output logic [63:0]                       csr_prdata,
   output logic                              csr_pready
);
   import tbt_pkg::*;

   // Work width: coordinate differences and band limits up to k*height.
   localparam int unsigned CB = COORD_BITS;
   localparam int unsigned WW = ((CB > HeightBits + 5) ? CB : HeightBits + 5) + 2;
   localparam int unsigned KB = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int unsigned QB = 3;   // result queue depth index bits

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_BAND  = 10'b0000000010,
      S_CLIP  = 10'b0000000100,
      S_IVAL  = 10'b0000001000,
      S_IWAIT = 10'b0000010000,
      S_CHECK = 10'b0000100000,
      S_EMIT  = 10'b0001000000,
      S_SEND  = 10'b0010000000,
      S_NEXT  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic [TileBits-1:0] tile;
      logic                kind;
      logic [CB-1:0]       x;
      logic [CB-1:0]       y;
      logic [CB-1:0]       z;
      logic [FeedBits-1:0] feed;
   } rsp_type;

   // Configuration.
   logic [HeightBits-1:0] height_ff;
   logic [CountBits-1:0]  count_ff;
   logic signed [CB-1:0]  safe_ff;
   logic                  wr_en;
   logic [1:0]            wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en  = csr_psel && csr_penable && csr_pwrite;
   assign wr_idx = csr_paddr[AddrBits-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HeightReset;
         count_ff  <= CountReset;
         safe_ff   <= CB'(SafeZReset);
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_TILE_HEIGHT: height_ff <= csr_pwdata[HeightBits-1:0];
            REG_TILE_COUNT:  count_ff  <= csr_pwdata[CountBits-1:0];
            REG_SAFE_Z:      safe_ff   <= csr_pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (wr_idx)
         REG_TILE_HEIGHT: csr_prdata = 64'(height_ff);
         REG_TILE_COUNT:  csr_prdata = 64'(count_ff);
         REG_SAFE_Z:      csr_prdata = 64'(signed'(safe_ff));
         default:         csr_prdata = '0;
      endcase
   end

   // Tracked state.
   state_type                state_ff, state_in;
   logic signed [CB-1:0]     pos_x_ff, pos_y_ff, pos_z_ff;
   logic [FeedBits-1:0]      plunge_ff;
   logic [MAX_TILES-1:0]     has_pos_ff;
   logic signed [CB-1:0]     last_x_ff [MAX_TILES];
   logic signed [CB-1:0]     last_y_ff [MAX_TILES];
   logic signed [CB-1:0]     last_z_ff [MAX_TILES];

   // Current item.
   logic signed [CB-1:0]     bx_ff, by_ff, bz_ff;
   logic [FeedBits-1:0]      fr_ff;
   logic [KB-1:0]            k_ff;
   logic [KB:0]              n_ff;
   logic signed [WW-1:0]     lo_ff, hi_ff;
   logic signed [WW-1:0]     den_ff, t0_ff, t1_ff;
   logic                     flat_ff;
   logic [2:0]               iv_ff;     // interpolation step 0..5, 6 when done
   logic signed [CB-1:0]     ca_ff [3];
   logic signed [CB-1:0]     cb_ff [3];

   // Result queue (per band: at most four results).
   rsp_type                  q_ff [4];
   logic [QB-1:0]            qn_ff, qi_ff;

   // Shared unit.
   div_ctl_type              dctl;
   logic [WW-1:0]            d_base, d_mag, d_num, d_den, d_res;
   logic                     d_busy;

   tbt_muldiv #(.W(WW)) u_muldiv (
      .clock(clock), .reset(reset), .ctl(dctl),
      .base(d_base), .mag(d_mag), .num(d_num), .den(d_den),
      .busy(d_busy), .result(d_res)
   );

   // Combinational helpers.
   logic signed [WW-1:0]     ay, dy, ia, ib, idiff, v;
   logic [KB:0]              n_eff;
   logic                     has_lo, has_hi, keep;
   logic [1:0]               axis;
   logic signed [CB-1:0]     lo_c;
   logic                     same_start;

   assign ay  = WW'(pos_y_ff);
   assign dy  = WW'(by_ff) - ay;
   assign has_lo = (k_ff != '0);
   assign has_hi = ({1'b0, k_ff} != n_ff - 1'b1);
   assign lo_c   = lo_ff[CB-1:0];

   always_comb begin
      if (count_ff == '0)
         n_eff = (KB+1)'(1);
      else if (32'(count_ff) > MAX_TILES)
         n_eff = (KB+1)'(MAX_TILES);
      else
         n_eff = (KB+1)'(count_ff);
   end

   always_comb begin
      axis = (iv_ff >= 3'd3) ? 2'(iv_ff - 3'd3) : iv_ff[1:0];
      unique case (axis)
         2'd0:    begin ia = WW'(pos_x_ff); ib = WW'(bx_ff); end
         2'd1:    begin ia = WW'(pos_y_ff); ib = WW'(by_ff); end
         default: begin ia = WW'(pos_z_ff); ib = WW'(bz_ff); end
      endcase
      idiff = ib - ia;
   end

   assign dctl   = '{start: (state_ff == S_IVAL), negate: idiff[WW-1]};
   assign d_base = ia;
   assign d_mag  = idiff[WW-1] ? -idiff : idiff;
   assign d_num  = (iv_ff < 3'd3) ? t0_ff : t1_ff;
   assign d_den  = den_ff;

   // Clip and survival for the current band.
   logic signed [WW-1:0] t0c, t1c;
   always_comb begin
      t0c = '0;
      t1c = dy[WW-1] ? -dy : dy;
      v   = '0;
      if (!dy[WW-1]) begin
         if (has_lo) begin v = lo_ff - ay; if (v > t0c) t0c = v; end
         if (has_hi) begin v = hi_ff - ay; if (v < t1c) t1c = v; end
      end else begin
         if (has_lo) begin v = ay - lo_ff; if (v < t1c) t1c = v; end
         if (has_hi) begin v = ay - hi_ff; if (v > t0c) t0c = v; end
      end
   end

   always_comb begin
      keep = !((ca_ff[0] == cb_ff[0]) && (ca_ff[1] == cb_ff[1]) && (ca_ff[2] == cb_ff[2]));
      if (!flat_ff && has_hi && (WW'(ca_ff[1]) >= hi_ff) && (WW'(cb_ff[1]) >= hi_ff))
         keep = 1'b0;
      same_start = has_pos_ff[k_ff] && (last_x_ff[k_ff] == ca_ff[0]) &&
                   (last_y_ff[k_ff] == ca_ff[1]) && (last_z_ff[k_ff] == ca_ff[2]);
   end

   logic [FeedBits-1:0] plunge_feed;
   assign plunge_feed = (plunge_ff != '0 && plunge_ff < fr_ff) ? plunge_ff : fr_ff;

   logic req_fire, rsp_fire;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_SEND);
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = req_func ? S_BAND : S_DONE;
         S_BAND:  state_in = S_CLIP;
         S_CLIP:  begin
            if (dy == '0)
               state_in = ((has_lo && ay < lo_ff) || (has_hi && ay >= hi_ff)) ? S_NEXT : S_CHECK;
            else
               state_in = (t1c <= t0c) ? S_NEXT : S_IVAL;
         end
         S_IVAL:  state_in = S_IWAIT;
         S_IWAIT: if (!d_busy) state_in = (iv_ff == 3'd5) ? S_CHECK : S_IVAL;
         S_CHECK: state_in = keep ? S_EMIT : S_NEXT;
         S_EMIT:  state_in = S_NEXT;
         S_NEXT:  state_in = (qn_ff != '0) ? S_SEND :
                             (({1'b0, k_ff} == n_ff - 1'b1) ? S_DONE : S_BAND);
         S_SEND:  if (rsp_fire && qi_ff + 1'b1 == qn_ff)
                     state_in = ({1'b0, k_ff} == n_ff - 1'b1) ? S_DONE : S_BAND;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= CB'(SafeZReset);
         plunge_ff  <= '0;
         has_pos_ff <= '0;
         qn_ff      <= '0;
         qi_ff      <= '0;
         iv_ff      <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: if (req_fire) begin
               bx_ff <= req_target_x; by_ff <= req_target_y; bz_ff <= req_target_z;
               fr_ff <= req_feed_rate;
               k_ff  <= '0;
               n_ff  <= n_eff;
               lo_ff <= '0;
               hi_ff <= WW'(height_ff);
               if (req_func && req_target_x == pos_x_ff && req_target_y == pos_y_ff &&
                   req_target_z < pos_z_ff)
                  plunge_ff <= req_feed_rate;
            end
            S_BAND: begin
               qn_ff <= '0;
               qi_ff <= '0;
            end
            S_CLIP: begin
               flat_ff <= (dy == '0);
               den_ff  <= dy[WW-1] ? -dy : dy;
               t0_ff   <= t0c;
               t1_ff   <= t1c;
               iv_ff   <= '0;
               ca_ff[0] <= pos_x_ff; ca_ff[1] <= pos_y_ff; ca_ff[2] <= pos_z_ff;
               cb_ff[0] <= bx_ff;    cb_ff[1] <= by_ff;    cb_ff[2] <= bz_ff;
            end
            S_IWAIT: if (!d_busy) begin
               if (iv_ff < 3'd3) ca_ff[axis] <= d_res[CB-1:0];
               else              cb_ff[axis] <= d_res[CB-1:0];
               iv_ff <= iv_ff + 1'b1;
            end
            S_EMIT: begin
               if (!same_start) begin
                  if (has_pos_ff[k_ff] && last_z_ff[k_ff] < safe_ff) begin
                     q_ff[0] <= '{TileBits'(k_ff), KIND_RAPID, last_x_ff[k_ff],
                                  last_y_ff[k_ff] - lo_c, safe_ff, '0};
                     q_ff[1] <= '{TileBits'(k_ff), KIND_RAPID, ca_ff[0],
                                  ca_ff[1] - lo_c, safe_ff, '0};
                     if (ca_ff[2] < safe_ff) begin
                        q_ff[2] <= '{TileBits'(k_ff), KIND_FEED, ca_ff[0],
                                     ca_ff[1] - lo_c, ca_ff[2], plunge_feed};
                        q_ff[3] <= '{TileBits'(k_ff), KIND_FEED, cb_ff[0],
                                     cb_ff[1] - lo_c, cb_ff[2], fr_ff};
                        qn_ff <= QB'(4);
                     end else begin
                        q_ff[2] <= '{TileBits'(k_ff), KIND_FEED, cb_ff[0],
                                     cb_ff[1] - lo_c, cb_ff[2], fr_ff};
                        qn_ff <= QB'(3);
                     end
                  end else begin
                     q_ff[0] <= '{TileBits'(k_ff), KIND_RAPID, ca_ff[0],
                                  ca_ff[1] - lo_c, safe_ff, '0};
                     if (ca_ff[2] < safe_ff) begin
                        q_ff[1] <= '{TileBits'(k_ff), KIND_FEED, ca_ff[0],
                                     ca_ff[1] - lo_c, ca_ff[2], plunge_feed};
                        q_ff[2] <= '{TileBits'(k_ff), KIND_FEED, cb_ff[0],
                                     cb_ff[1] - lo_c, cb_ff[2], fr_ff};
                        qn_ff <= QB'(3);
                     end else begin
                        q_ff[1] <= '{TileBits'(k_ff), KIND_FEED, cb_ff[0],
                                     cb_ff[1] - lo_c, cb_ff[2], fr_ff};
                        qn_ff <= QB'(2);
                     end
                  end
               end else begin
                  q_ff[0] <= '{TileBits'(k_ff), KIND_FEED, cb_ff[0],
                               cb_ff[1] - lo_c, cb_ff[2], fr_ff};
                  qn_ff <= QB'(1);
               end
               last_x_ff[k_ff] <= cb_ff[0];
               last_y_ff[k_ff] <= cb_ff[1];
               last_z_ff[k_ff] <= cb_ff[2];
               has_pos_ff[k_ff] <= 1'b1;
            end
            S_NEXT: begin
               if (state_in != S_SEND) begin
                  k_ff  <= k_ff + 1'b1;
                  lo_ff <= hi_ff;
                  hi_ff <= hi_ff + WW'(height_ff);
               end
            end
            S_SEND: if (rsp_fire) begin
               qi_ff <= qi_ff + 1'b1;
               if (qi_ff + 1'b1 == qn_ff) begin
                  k_ff  <= k_ff + 1'b1;
                  lo_ff <= hi_ff;
                  hi_ff <= hi_ff + WW'(height_ff);
               end
            end
            S_DONE: begin
               pos_x_ff <= bx_ff; pos_y_ff <= by_ff; pos_z_ff <= bz_ff;
            end
            default: ;
         endcase
         if (state_ff == S_IDLE && req_fire && !req_func) begin
            pos_x_ff <= req_target_x; pos_y_ff <= req_target_y; pos_z_ff <= req_target_z;
         end
      end
   end

   // rsp_last: final queued result, and no later band keeps a piece. A flat
   // segment lies in exactly one band. A sloped segment has its y clipped
   // exactly, so a later band keeps a piece exactly when the segment rises
   // above the upper limit of this band.
   logic signed [WW-1:0] ymax;
   logic                 later;
   assign ymax  = (WW'(by_ff) > ay) ? WW'(by_ff) : ay;
   always_comb begin
      if (!has_hi)
         later = 1'b0;
      else if (dy == '0)
         later = 1'b0;
      else
         later = (ymax > hi_ff);
   end

   assign rsp_tile_index = q_ff[qi_ff[1:0]].tile;
   assign rsp_move_kind  = q_ff[qi_ff[1:0]].kind;
   assign rsp_out_x      = q_ff[qi_ff[1:0]].x;
   assign rsp_out_y      = q_ff[qi_ff[1:0]].y;
   assign rsp_out_z      = q_ff[qi_ff[1:0]].z;
   assign rsp_out_feed   = q_ff[qi_ff[1:0]].feed;
   assign rsp_last       = (qi_ff + 1'b1 == qn_ff) && !later;

   // Assertions.
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (qi_ff < qn_ff)) else $error("result index past queue");
   a_div_idle_on_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !d_busy) else $error("divider busy while sending");

endmodule
`default_nettype wire

/* src/tbt_muldiv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbt_muldiv
// Shared serial unit: a + sign * floor(|d| * n / den), one quotient bit per
// cycle. The product |d|*n is formed by shift-and-add, one bit per cycle, and
// then divided by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module tbt_muldiv #(
   parameter int unsigned W = 42
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tbt_pkg::div_ctl_type ctl,
   input  wire logic [W-1:0]         base,
   input  wire logic [W-1:0]         mag,
   input  wire logic [W-1:0]         num,
   input  wire logic [W-1:0]         den,
   output logic                      busy,
   output logic [W-1:0]              result
);
   import tbt_pkg::*;

   localparam int unsigned PW = 2 * W;
   localparam int unsigned CW = $clog2(PW + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_DIV  = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [W-1:0]    mcand_ff, mcand_in;
   logic [W-1:0]    mplier_ff, mplier_in;
   logic [W:0]      rem_ff, rem_in;
   logic [W-1:0]    q_ff, q_in;
   logic [W-1:0]    den_ff, den_in;
   logic [W-1:0]    base_ff, base_in;
   logic            neg_ff, neg_in;
   logic [W-1:0]    result_ff, result_in;
   logic [W:0]      trial;
   logic [W:0]      shifted;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      den_in    = den_ff;
      base_in   = base_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      shifted   = {rem_ff[W-1:0], prod_ff[PW-1]};
      trial     = shifted - {1'b0, den_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               state_in  = S_MUL;
               cnt_in    = CW'(W);
               prod_in   = '0;
               mcand_in  = mag;
               mplier_in = num;
               den_in    = den;
               base_in   = base;
               neg_in    = ctl.negate;
            end
         end
         S_MUL: begin
            // Multiplier bits from the top down: prod = 2*prod + bit*mcand.
            prod_in   = {prod_ff[PW-2:0], 1'b0} +
                        (mplier_ff[W-1] ? {{W{1'b0}}, mcand_ff} : '0);
            mplier_in = {mplier_ff[W-2:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = S_DIV;
               cnt_in   = CW'(PW);
               rem_in   = '0;
               q_in     = '0;
            end
         end
         S_DIV: begin
            prod_in = {prod_ff[PW-2:0], 1'b0};
            if (!trial[W]) begin
               rem_in = trial;
               q_in   = {q_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               q_in   = {q_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in  = S_IDLE;
               result_in = neg_ff ? base_ff - q_in : base_ff + q_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      den_ff    <= den_in;
      base_ff   <= base_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign busy   = (state_ff != S_IDLE) || ctl.start;
   assign result = result_ff;

endmodule
`default_nettype wire

/* tb/toolpath_band_tiler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toolpath_band_tiler_tb
// Self-checking bench for the band tiler: rapid and feed moves go in on the
// req_ channel and a behavioral band splitter in the bench predicts every
// retract, relink, plunge and clipped piece on the rsp_ channel. Directed
// tests cover plunges, relinking, band boundaries and register extremes;
// random phases run several band settings with idling and a receiver stall.
// ----------------------------------------------------------------------------
module toolpath_band_tiler_tb;
   import tbt_pkg::*;

   localparam int     NumBands      = 16;
   localparam longint CoordMax      = 64'sd549755813887;
   localparam longint CoordMin      = -64'sd549755813888;
   localparam longint HeightMax     = 64'sd549755813887;
   localparam int     RegUnused     = 3;
   localparam int     SettleCycles  = 13000;
   localparam int     WatchdogLimit = 100000;
   localparam int     HoldCycles    = 3000;

   typedef struct {
      logic [3:0]         tile;
      logic               kind;
      logic signed [39:0] x;
      logic signed [39:0] y;
      logic signed [39:0] z;
      logic [15:0]        feed;
      logic               last;
   } band_move_type;

   typedef longint point_type [3];

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = 1'b0;
   logic signed [39:0] req_target_x = '0;
   logic signed [39:0] req_target_y = '0;
   logic signed [39:0] req_target_z = '0;
   logic [15:0]        req_feed_rate = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_tile_index;
   logic               rsp_move_kind;
   logic signed [39:0] rsp_out_x;
   logic signed [39:0] rsp_out_y;
   logic signed [39:0] rsp_out_z;
   logic [15:0]        rsp_out_feed;
   logic               rsp_last;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [4:0]         csr_paddr = '0;
   logic [63:0]        csr_pwdata = '0;
   logic [63:0]        csr_prdata;
   logic               csr_pready;

   // Predictor state: registers, tool position and per-band last position.
   longint cfg_height = 64'sd508000000;
   int     cfg_count  = 1;
   longint cfg_safe_z = 64'sd5000000;
   longint tool_x = 0, tool_y = 0, tool_z = 64'sd5000000;
   longint plunge_feed = 0;
   longint band_x [NumBands];
   longint band_y [NumBands];
   longint band_z [NumBands];
   bit     band_seen [NumBands];

   band_move_type expected_moves [$];

   int  mismatches = 0;
   int  moves_sent = 0;
   int  moves_checked = 0;
   int  csr_writes = 0;
   int  hold_count = 0;
   bit  calm = 1'b0;
   bit  failed = 1'b0;

   toolpath_band_tiler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z), .req_feed_rate(req_feed_rate),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tile_index(rsp_tile_index), .rsp_move_kind(rsp_move_kind),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_out_feed(rsp_out_feed), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // a + trunc((b-a)*n/den), exact with a wide product.
   function automatic longint scale_step(longint a, longint b, longint n, longint den);
      longint     d;
      logic [127:0] p;
      longint     m;
      d = b - a;
      if (d >= 0) begin
         p = 128'(d) * 128'(n);
         m = longint'(p / 128'(den));
         return a + m;
      end
      p = 128'(-d) * 128'(n);
      m = longint'(p / 128'(den));
      return a - m;
   endfunction

   function automatic bit clip_to_band(point_type a, point_type b, bit has_lo, longint lo,
                                       bit has_hi, longint hi, output point_type c0,
                                       output point_type c1);
      longint dy, den, t0, t1, v;
      dy = b[1] - a[1];
      if (dy == 0) begin
         if ((has_lo && a[1] < lo) || (has_hi && a[1] >= hi))
            return 1'b0;
         c0 = a;
         c1 = b;
      end else begin
         den = dy > 0 ? dy : -dy;
         t0 = 0;
         t1 = den;
         if (dy > 0) begin
            if (has_lo) begin v = lo - a[1]; if (v > t0) t0 = v; end
            if (has_hi) begin v = hi - a[1]; if (v < t1) t1 = v; end
         end else begin
            if (has_lo) begin v = a[1] - lo; if (v < t1) t1 = v; end
            if (has_hi) begin v = a[1] - hi; if (v > t0) t0 = v; end
         end
         if (t1 <= t0)
            return 1'b0;
         for (int i = 0; i < 3; i++) begin
            c0[i] = scale_step(a[i], b[i], t0, den);
            c1[i] = scale_step(a[i], b[i], t1, den);
         end
         // A piece lying wholly on the upper edge belongs to the next band.
         if (has_hi && c0[1] >= hi && c1[1] >= hi)
            return 1'b0;
      end
      return !(c0[0] == c1[0] && c0[1] == c1[1] && c0[2] == c1[2]);
   endfunction

   function automatic void push_move(int k, logic kind, longint x, longint y, longint z,
                                     longint feed);
      band_move_type m;
      m.tile = 4'(k);
      m.kind = kind;
      m.x    = 40'(x);
      m.y    = 40'(y);
      m.z    = 40'(z);
      m.feed = 16'(feed);
      m.last = 1'b0;
      expected_moves.push_back(m);
   endfunction

   function automatic void split_move(logic func, logic signed [39:0] tx,
                                      logic signed [39:0] ty, logic signed [39:0] tz,
                                      logic [15:0] feed);
      point_type a, b, c0, c1;
      longint lo, hi, fr;
      int     bands, prev_size;
      a = '{tool_x, tool_y, tool_z};
      b = '{longint'(tx), longint'(ty), longint'(tz)};
      fr = longint'(feed);
      prev_size = expected_moves.size();
      if (func == KIND_FEED) begin
         if (b[0] == a[0] && b[1] == a[1] && b[2] < a[2])
            plunge_feed = fr;
         bands = cfg_count == 0 ? 1 : (cfg_count > NumBands ? NumBands : cfg_count);
         for (int k = 0; k < bands; k++) begin
            lo = longint'(k) * cfg_height;
            hi = longint'(k + 1) * cfg_height;
            if (!clip_to_band(a, b, k > 0, lo, k < bands - 1, hi, c0, c1))
               continue;
            if (!band_seen[k] || band_x[k] != c0[0] || band_y[k] != c0[1] ||
                band_z[k] != c0[2]) begin
               if (band_seen[k] && band_z[k] < cfg_safe_z)
                  push_move(k, KIND_RAPID, band_x[k], band_y[k] - lo, cfg_safe_z, 0);
               push_move(k, KIND_RAPID, c0[0], c0[1] - lo, cfg_safe_z, 0);
               if (c0[2] < cfg_safe_z)
                  push_move(k, KIND_FEED, c0[0], c0[1] - lo, c0[2],
                            (plunge_feed > 0 && plunge_feed < fr) ? plunge_feed : fr);
            end
            push_move(k, KIND_FEED, c1[0], c1[1] - lo, c1[2], fr);
            band_x[k] = c1[0];
            band_y[k] = c1[1];
            band_z[k] = c1[2];
            band_seen[k] = 1'b1;
         end
         if (expected_moves.size() > prev_size)
            expected_moves[expected_moves.size() - 1].last = 1'b1;
      end
      tool_x = b[0];
      tool_y = b[1];
      tool_z = b[2];
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_move(logic func, longint x, longint y, longint z, int feed);
      if (!calm && $urandom_range(0, 99) < 16) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid     = 1'b1;
      req_func      = func;
      req_target_x  = 40'(x);
      req_target_y  = 40'(y);
      req_target_z  = 40'(z);
      req_feed_rate = 16'(feed);
      do @(posedge clock); while (!req_ready);
      split_move(req_func, req_target_x, req_target_y, req_target_z, req_feed_rate);
      moves_sent++;
   endtask

   task automatic write_csr(int index, longint value);
      @(negedge clock);
      req_valid   = 1'b0;
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = 5'(index * 8);
      csr_pwdata  = 64'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_TILE_HEIGHT: cfg_height = longint'(value[38:0]);
         REG_TILE_COUNT:  cfg_count = int'(value[4:0]);
         REG_SAFE_Z:      cfg_safe_z = longint'($signed(value[39:0]));
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Wait until every expected result is back, then let a feed with no
   // surviving piece finish before touching the registers.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic configure(longint height, int count, longint safe_z);
      settle();
      write_csr(REG_TILE_HEIGHT, height);
      write_csr(REG_TILE_COUNT, count);
      write_csr(REG_SAFE_Z, safe_z);
   endtask

   function automatic longint rand_between(longint lo, longint hi);
      longint unsigned r;
      r = {$urandom, $urandom};
      if (hi <= lo)
         return lo;
      return lo + longint'(r % longint'(hi - lo + 1));
   endfunction

   function automatic longint rand_coord();
      return longint'($signed(40'({$urandom, $urandom})));
   endfunction

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      band_move_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_moves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: tile %0d kind %0d (%0d,%0d,%0d) feed %0d",
                        rsp_tile_index, rsp_move_kind, rsp_out_x, rsp_out_y, rsp_out_z,
                        rsp_out_feed);
         end else begin
            e = expected_moves.pop_front();
            moves_checked++;
            if (rsp_tile_index !== e.tile || rsp_move_kind !== e.kind ||
                rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z ||
                rsp_out_feed !== e.feed || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected tile %0d kind %0d (%0d,%0d,%0d) feed %0d last %0d",
                           e.tile, e.kind, e.x, e.y, e.z, e.feed, e.last);
                  $display("          actual   tile %0d kind %0d (%0d,%0d,%0d) feed %0d last %0d",
                           rsp_tile_index, rsp_move_kind, rsp_out_x, rsp_out_y, rsp_out_z,
                           rsp_out_feed, rsp_last);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_count > 0) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count - 1;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 16);
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("timeout with %0d results outstanding", expected_moves.size());
         $display("[toolpath_band_tiler] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_plunge_and_relink();
      send_move(KIND_RAPID, 0, 0, 10000000, 0);
      send_move(KIND_FEED, 0, 0, -1000000, 300);           // plunge sets the plunge feed
      send_move(KIND_FEED, 2000000, 3000000, -1000000, 800);
      send_move(KIND_RAPID, 5000000, 5000000, 1000000, 0);
      send_move(KIND_FEED, 6000000, 5000000, -2000000, 900); // full relink
      send_move(KIND_FEED, 6000000, 5000000, -2000000, 900); // zero length
      send_move(KIND_RAPID, CoordMax, CoordMax, CoordMax, 0);
      send_move(KIND_FEED, CoordMin, CoordMin, CoordMin, 65535);
      send_move(KIND_FEED, CoordMax, CoordMax, CoordMax, 1);
   endtask

   task automatic test_band_boundaries();
      configure(1000, 4, 500);
      send_move(KIND_RAPID, 0, -300, 800, 0);
      send_move(KIND_FEED, 100, 4500, -20, 1200);          // crosses every band
      send_move(KIND_RAPID, 0, 1000, 0, 0);
      send_move(KIND_FEED, 50, 1000, 0, 700);              // flat on a boundary
      send_move(KIND_FEED, 50, 1000, -10, 250);
      send_move(KIND_FEED, 50, -700, 100, 2000);           // descending
      send_move(KIND_FEED, 70, 3000, 600, 0);              // above safe height
      send_move(KIND_FEED, 90, 2000, 600, 400);            // ends on a boundary
   endtask

   task automatic test_register_extremes();
      configure(1, 0, CoordMin);
      write_csr(RegUnused, 64'h0000_0000_0000_0005);
      send_move(KIND_FEED, -5, 7, 3, 100);
      send_move(KIND_FEED, 3, -4, -3, 65535);
      configure(HeightMax, 17, CoordMax);
      send_move(KIND_FEED, 1, CoordMax, 0, 500);
      send_move(KIND_FEED, 2, CoordMin, -1, 600);
      configure(3, 31, 0);
      send_move(KIND_FEED, 0, 60, -2, 10);
   endtask

   // With stall set, the receiver holds off right after the registers are
   // written, while the items of this phase keep coming.
   task automatic random_phase(longint height, int count, longint safe_z, int items,
                               bit stall);
      longint span_lo, span_hi, x, y, z;
      int     r;
      configure(height, count, safe_z);
      if (stall)
         hold_count = HoldCycles;
      span_lo = -(height / 2) - 1;
      span_hi = (count > NumBands ? NumBands : count) * height + height / 2;
      if (span_hi > CoordMax) span_hi = CoordMax;
      if (span_lo < CoordMin) span_lo = CoordMin;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         x = rand_between(-5000, 5000);
         y = rand_between(span_lo, span_hi);
         z = rand_between(safe_z - 2000, safe_z + 2000);
         if (r < 15)
            send_move(KIND_RAPID, x, y, z, $urandom_range(0, 65535));
         else if (r < 25)
            send_move(KIND_FEED, tool_x, tool_y, tool_z - rand_between(1, 3000),
                      $urandom_range(0, 65535));
         else if (r < 90)
            send_move(KIND_FEED, x, y, z, $urandom_range(0, 65535));
         else
            send_move(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 65535));
      end
   endtask

   task automatic test_random_with_stall();
      calm = 1'b1;
      random_phase(1000, 4, 0, 60, 1'b0);
      calm = 1'b0;
      random_phase(37, 16, -100, 38, 1'b1);
      random_phase(rand_between(1, 1 << 20), $urandom_range(1, 16), rand_between(-3000, 3000),
                   60, 1'b0);
      random_phase(HeightMax, 3, 0, 30, 1'b0);
   endtask

   initial begin
      for (int k = 0; k < NumBands; k++) begin
         band_x[k] = 0;
         band_y[k] = 0;
         band_z[k] = 0;
         band_seen[k] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_plunge_and_relink();
      test_band_boundaries();
      test_register_extremes();
      test_random_with_stall();
      settle();

      if (expected_moves.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", expected_moves.size());
      end
      $display("Sent %0d moves, checked %0d band moves over %0d register writes.",
               moves_sent, moves_checked, csr_writes);
      $display("Covered relinks, plunges, band edges, register extremes and a long stall.");
      failed = mismatches != 0;
      if (!failed)
         $display("[toolpath_band_tiler] OK");
      else
         $display("[toolpath_band_tiler] ERROR");
      $finish;
   end

endmodule

/* files.f */
src/tbt_pkg.sv
src/tbt_muldiv.sv
src/toolpath_band_tiler.sv
tb/toolpath_band_tiler_tb.sv
